// ===== rtl/lgst_pkg.sv =====
// ----------------------------------------------------------------------------
// lgst_pkg
// Shared types and constants for the light-gate speed timer.
// ----------------------------------------------------------------------------
package lgst_pkg;

    // fixed field widths
    localparam int SAMPLE_W = 12;
    localparam int DIST_W   = 7;
    localparam int MS_W     = 22;
    localparam int MIN_W    = 6;
    localparam int SEC_W    = 6;
    localparam int TENTH_W  = 4;
    localparam int SUB_W    = 7;   // ms within a tenth, 0..99
    localparam int SPEED_W  = 17;
    localparam int PHASE_W  = 2;
    localparam int CFG_IDX_W = 2;

    // run phase codes
    localparam logic [PHASE_W-1:0] PH_IDLE = 2'd0;
    localparam logic [PHASE_W-1:0] PH_RUN  = 2'd1;
    localparam logic [PHASE_W-1:0] PH_DONE = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_START_THR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_THR  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DISTANCE  = 2'd2;

    // register reset values
    localparam logic [SAMPLE_W-1:0] START_THR_RST = 12'd170;
    localparam logic [SAMPLE_W-1:0] STOP_THR_RST  = 12'd200;
    localparam logic [DIST_W-1:0]   DISTANCE_RST  = 7'd20;

    // time digit limits
    localparam logic [SUB_W-1:0]   MS_PER_TENTH    = 7'd100;
    localparam logic [TENTH_W-1:0] TENTHS_PER_SEC  = 4'd10;
    localparam logic [SEC_W-1:0]   SECS_PER_MIN    = 6'd60;

    // speed = distance_dm * 10000 / ms, in hundredths of m/s
    localparam int DVD_W = 21;
    localparam logic [DVD_W-1:0]   SPEED_SCALE = 21'd10000;
    localparam logic [DVD_W-1:0]   SPEED_MAX   = 21'd100000;
    localparam int DIV_CNT_W = 5;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = 5'(DVD_W - 1);

    // controller to datapath commands
    typedef struct packed {
        logic capture;    // latch input transaction
        logic step;       // apply one tick to the timer state
        logic div_step;   // one quotient bit
        logic spd_load;   // write saturated quotient to speed
        logic out_load;   // load result register
    } lgst_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic stop_hit;   // this tick ends timing, speed needed
    } lgst_sts_t;

endpackage

// ===== rtl/light_gate_speed_timer.sv =====
// ----------------------------------------------------------------------------
// light_gate_speed_timer
// Two-beam light-gate timer: one transaction per 1 ms tick, one result each.
// ----------------------------------------------------------------------------
//  channel | ports                                          | direction
//  --------+------------------------------------------------+----------
//  s_      | s_valid/s_ready, start/stop samples, enable,   | in
//          | clear                                          |
//  m_      | m_valid/m_ready, phase, time, speed, flags     | out
//  cfg_    | cfg_we, cfg_index, cfg_wdata (write only)      | in
//
//  A tick passes capture, update and result load; the tick that ends timing
//  also runs the bit-serial restoring divider (21 quotient bits, then
//  saturation into the speed register) before the result load.
//  One tick is in flight at a time; a new tick is taken while the previous
//  result still sits in the output register, and waits before loading it.
//  Reset (synchronous, active low) returns to idle with all time zeroed and
//  the registers at 170 / 200 / 20.
// ----------------------------------------------------------------------------
module light_gate_speed_timer
    import lgst_pkg::*;
#(
    parameter int SAMPLE_BITS = 12,
    parameter int MAX_MINUTES = 60
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SAMPLE_W-1:0]  cfg_wdata,
    // tick input
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [SAMPLE_W-1:0]  s_start_sample,
    input  logic [SAMPLE_W-1:0]  s_stop_sample,
    input  logic                 s_start_enable,
    input  logic                 s_clear,
    // result output
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [PHASE_W-1:0]   m_phase,
    output logic [MS_W-1:0]      m_elapsed_ms,
    output logic [MIN_W-1:0]     m_minutes,
    output logic [SEC_W-1:0]     m_seconds,
    output logic [TENTH_W-1:0]   m_tenths,
    output logic [SPEED_W-1:0]   m_speed_centi,
    output logic                 m_started,
    output logic                 m_stopped,
    output logic                 m_overflow
);

    lgst_cmd_t cmd;
    lgst_sts_t sts;

    // sequencer: owns the handshakes and the divider step count
    lgst_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // datapath: registers, time digits, divider, result register
    lgst_dp #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .MAX_MINUTES (MAX_MINUTES)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_start_sample (s_start_sample),
        .s_stop_sample  (s_stop_sample),
        .s_start_enable (s_start_enable),
        .s_clear        (s_clear),
        .cmd            (cmd),
        .sts            (sts),
        .m_phase        (m_phase),
        .m_elapsed_ms   (m_elapsed_ms),
        .m_minutes      (m_minutes),
        .m_seconds      (m_seconds),
        .m_tenths       (m_tenths),
        .m_speed_centi  (m_speed_centi),
        .m_started      (m_started),
        .m_stopped      (m_stopped),
        .m_overflow     (m_overflow)
    );

endmodule

// ===== rtl/lgst_ctrl.sv =====
// ----------------------------------------------------------------------------
// lgst_ctrl
// Sequencer: input capture, tick update, speed division, result hand-off.
// ----------------------------------------------------------------------------
module lgst_ctrl
    import lgst_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  logic      m_ready,
    input  lgst_sts_t sts,
    output lgst_cmd_t cmd
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_CALC = 5'b00010,
        ST_DIV  = 5'b00100,
        ST_SPD  = 5'b01000,
        ST_PUT  = 5'b10000
    } state_t;

    state_t               state_reg, state_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic                 m_valid_reg, m_valid_next;
    logic                 out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        div_cnt_next = div_cnt_reg;
        m_valid_next = m_valid_reg;
        cmd          = '0;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_CALC;
                end
            end
            ST_CALC: begin
                cmd.step     = 1'b1;
                div_cnt_next = '0;
                state_next   = sts.stop_hit ? ST_DIV : ST_PUT;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == DIV_LAST) begin
                    state_next = ST_SPD;
                end
            end
            ST_SPD: begin
                cmd.spd_load = 1'b1;
                state_next   = ST_PUT;
            end
            ST_PUT: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            div_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            div_cnt_reg <= div_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ===== rtl/lgst_dp.sv =====
// ----------------------------------------------------------------------------
// lgst_dp
// Datapath: registers, timer state and digits, restoring divider, result.
// ----------------------------------------------------------------------------
module lgst_dp
    import lgst_pkg::*;
#(
    parameter int SAMPLE_BITS = 12,
    parameter int MAX_MINUTES = 60
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SAMPLE_W-1:0]  cfg_wdata,
    input  logic [SAMPLE_W-1:0]  s_start_sample,
    input  logic [SAMPLE_W-1:0]  s_stop_sample,
    input  logic                 s_start_enable,
    input  logic                 s_clear,
    input  lgst_cmd_t            cmd,
    output lgst_sts_t            sts,
    output logic [PHASE_W-1:0]   m_phase,
    output logic [MS_W-1:0]      m_elapsed_ms,
    output logic [MIN_W-1:0]     m_minutes,
    output logic [SEC_W-1:0]     m_seconds,
    output logic [TENTH_W-1:0]   m_tenths,
    output logic [SPEED_W-1:0]   m_speed_centi,
    output logic                 m_started,
    output logic                 m_stopped,
    output logic                 m_overflow
);

    localparam int CMP_BITS = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
    localparam logic [MS_W-1:0] MS_LIMIT = MS_W'(MAX_MINUTES * 60000 - 1);

    // configuration
    logic [SAMPLE_W-1:0] start_thr_reg, stop_thr_reg;
    logic [DIST_W-1:0]   dist_reg;

    // captured tick
    logic [SAMPLE_W-1:0] in_start_reg, in_stop_reg;
    logic                in_enable_reg, in_clear_reg;

    // timer state
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [MS_W-1:0]    ms_reg, ms_next;
    logic               armed_reg, armed_next;
    logic [SUB_W-1:0]   sub_reg, sub_next;
    logic [TENTH_W-1:0] tenth_reg, tenth_next;
    logic [SEC_W-1:0]   sec_reg, sec_next;
    logic [MIN_W-1:0]   min_reg, min_next;
    logic [SPEED_W-1:0] speed_reg, speed_next;
    logic               ovf_reg, ovf_next;
    logic               began_reg, began_next;
    logic               ended_reg, ended_next;

    // divider
    logic [MS_W-1:0]  rem_reg, rem_next;
    logic [DVD_W-1:0] dq_reg, dq_next;
    logic [MS_W:0]    trial;
    logic [DVD_W-1:0] dividend;
    logic [SPEED_W-1:0] speed_sat;

    logic start_above, stop_above;

    assign start_above = in_start_reg[CMP_BITS-1:0] > start_thr_reg[CMP_BITS-1:0];
    assign stop_above  = in_stop_reg[CMP_BITS-1:0] > stop_thr_reg[CMP_BITS-1:0];

    assign sts.stop_hit = !in_clear_reg && (phase_reg == PH_RUN) && stop_above && armed_reg;

    // tick update
    always_comb begin
        phase_next = phase_reg;
        ms_next    = ms_reg;
        armed_next = armed_reg;
        sub_next   = sub_reg;
        tenth_next = tenth_reg;
        sec_next   = sec_reg;
        min_next   = min_reg;
        speed_next = speed_reg;
        ovf_next   = ovf_reg;
        began_next = 1'b0;
        ended_next = 1'b0;
        if (in_clear_reg) begin
            phase_next = PH_IDLE;
            ms_next    = '0;
            armed_next = 1'b0;
            sub_next   = '0;
            tenth_next = '0;
            sec_next   = '0;
            min_next   = '0;
            speed_next = '0;
            ovf_next   = 1'b0;
        end else begin
            case (phase_reg)
                PH_RUN: begin
                    if (ms_reg >= MS_LIMIT) begin
                        ovf_next = 1'b1;
                    end else begin
                        ms_next = ms_reg + 1'b1;
                        if (ms_reg == MS_LIMIT - 1'b1) begin
                            ovf_next = 1'b1;
                        end
                        if (sub_reg + 1'b1 >= MS_PER_TENTH) begin
                            sub_next = '0;
                            if (tenth_reg + 1'b1 >= TENTHS_PER_SEC) begin
                                tenth_next = '0;
                                if (sec_reg + 1'b1 >= SECS_PER_MIN) begin
                                    sec_next = '0;
                                    min_next = min_reg + 1'b1;
                                end else begin
                                    sec_next = sec_reg + 1'b1;
                                end
                            end else begin
                                tenth_next = tenth_reg + 1'b1;
                            end
                        end else begin
                            sub_next = sub_reg + 1'b1;
                        end
                    end
                    if (!stop_above) begin
                        armed_next = 1'b1;
                    end else if (armed_reg) begin
                        phase_next = PH_DONE;
                        ended_next = 1'b1;
                    end
                end
                PH_IDLE: begin
                    if (in_enable_reg && start_above) begin
                        phase_next = PH_RUN;
                        began_next = 1'b1;
                        ms_next    = '0;
                        armed_next = 1'b0;
                        sub_next   = '0;
                        tenth_next = '0;
                        sec_next   = '0;
                        min_next   = '0;
                        speed_next = '0;
                        ovf_next   = 1'b0;
                    end
                end
                default: begin
                    phase_next = PH_DONE;
                end
            endcase
        end
    end

    // restoring divider, one quotient bit per cycle; divisor is the
    // already updated ms count
    assign dividend = DVD_W'(dist_reg) * SPEED_SCALE;
    assign trial    = {rem_reg, dq_reg[DVD_W-1]} - {1'b0, ms_reg};

    always_comb begin
        rem_next = rem_reg;
        dq_next  = dq_reg;
        if (cmd.step) begin
            rem_next = '0;
            dq_next  = dividend;
        end else if (cmd.div_step) begin
            if (!trial[MS_W]) begin
                rem_next = trial[MS_W-1:0];
                dq_next  = {dq_reg[DVD_W-2:0], 1'b1};
            end else begin
                rem_next = {rem_reg[MS_W-2:0], dq_reg[DVD_W-1]};
                dq_next  = {dq_reg[DVD_W-2:0], 1'b0};
            end
        end
    end

    always_comb begin
        if (ms_reg == '0) begin
            speed_sat = '0;
        end else if (dq_reg > SPEED_MAX) begin
            speed_sat = SPEED_MAX[SPEED_W-1:0];
        end else begin
            speed_sat = dq_reg[SPEED_W-1:0];
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_thr_reg <= START_THR_RST;
            stop_thr_reg  <= STOP_THR_RST;
            dist_reg      <= DISTANCE_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_START_THR: start_thr_reg <= cfg_wdata;
                REG_STOP_THR:  stop_thr_reg  <= cfg_wdata;
                REG_DISTANCE:  dist_reg      <= cfg_wdata[DIST_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // timer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            ms_reg    <= '0;
            armed_reg <= 1'b0;
            sub_reg   <= '0;
            tenth_reg <= '0;
            sec_reg   <= '0;
            min_reg   <= '0;
            speed_reg <= '0;
            ovf_reg   <= 1'b0;
            began_reg <= 1'b0;
            ended_reg <= 1'b0;
        end else if (cmd.step) begin
            phase_reg <= phase_next;
            ms_reg    <= ms_next;
            armed_reg <= armed_next;
            sub_reg   <= sub_next;
            tenth_reg <= tenth_next;
            sec_reg   <= sec_next;
            min_reg   <= min_next;
            speed_reg <= speed_next;
            ovf_reg   <= ovf_next;
            began_reg <= began_next;
            ended_reg <= ended_next;
        end else if (cmd.spd_load) begin
            speed_reg <= speed_sat;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        dq_reg  <= dq_next;
        if (cmd.capture) begin
            in_start_reg  <= s_start_sample;
            in_stop_reg   <= s_stop_sample;
            in_enable_reg <= s_start_enable;
            in_clear_reg  <= s_clear;
        end
        if (cmd.out_load) begin
            m_phase       <= phase_reg;
            m_elapsed_ms  <= ms_reg;
            m_minutes     <= min_reg;
            m_seconds     <= sec_reg;
            m_tenths      <= tenth_reg;
            m_speed_centi <= (phase_reg == PH_DONE) ? speed_reg : '0;
            m_started     <= began_reg;
            m_stopped     <= ended_reg;
            m_overflow    <= ovf_reg;
        end
    end

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the light-gate speed timer. Every accepted tick runs
// through a local timer predictor; each result transaction is compared field
// by field with the oldest predicted one. A short table of directed ticks
// comes first, then random measurements under several register settings.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import lgst_pkg::*;

    localparam int CLK_PERIOD   = 4;
    localparam int RESET_CYCLES = 8;
    // the hour limit as built; a run long enough to reach it is not attempted
    localparam int          MAX_MIN     = 60;
    localparam int unsigned MS_LIMIT    = MAX_MIN * 60000 - 1;
    localparam int          SAMPLE_MAX  = (1 << SAMPLE_W) - 1;
    localparam int          MAX_GAP     = 9;
    // a stop tick also runs the divider inside the block; leave margin after that
    localparam int          DRAIN_CYCLES = 40;
    // one long receiver hold-off once this many results have come in
    localparam int unsigned HOLD_AT      = 300;
    localparam int          HOLD_CYCLES  = 400;
    // watchdog limit on the whole run
    localparam int unsigned CYCLE_LIMIT  = 500_000;
    localparam int unsigned MAX_REPORTS  = 200;
    // random ticks per register setting
    localparam int unsigned PHASE_TICKS [5] = '{350, 300, 50, 275, 275};

    // ------------------------------------------------------------------------
    // transaction types
    // ------------------------------------------------------------------------
    typedef struct packed {
        logic [SAMPLE_W-1:0] start_sample;
        logic [SAMPLE_W-1:0] stop_sample;
        logic                start_enable;
        logic                clear;
    } tick_t;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [MS_W-1:0]    elapsed_ms;
        logic [MIN_W-1:0]   minutes;
        logic [SEC_W-1:0]   seconds;
        logic [TENTH_W-1:0] tenths;
        logic [SPEED_W-1:0] speed_centi;
        logic               started;
        logic               stopped;
        logic               overflow;
    } gate_result_t;

    // one row of the directed table; want is used only where typed is set
    typedef struct packed {
        tick_t        stim;
        logic         typed;
        gate_result_t want;
    } dir_row_t;

    localparam gate_result_t R_IDLE  = '{phase: PH_IDLE, default: '0};
    localparam gate_result_t R_START = '{phase: PH_RUN, started: 1'b1, default: '0};

    // ------------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------------
    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [SAMPLE_W-1:0]  cfg_wdata;
    logic                 s_valid;
    logic                 s_ready;
    logic [SAMPLE_W-1:0]  s_start_sample;
    logic [SAMPLE_W-1:0]  s_stop_sample;
    logic                 s_start_enable;
    logic                 s_clear;
    logic                 m_valid;
    logic                 m_ready;
    logic [PHASE_W-1:0]   m_phase;
    logic [MS_W-1:0]      m_elapsed_ms;
    logic [MIN_W-1:0]     m_minutes;
    logic [SEC_W-1:0]     m_seconds;
    logic [TENTH_W-1:0]   m_tenths;
    logic [SPEED_W-1:0]   m_speed_centi;
    logic                 m_started;
    logic                 m_stopped;
    logic                 m_overflow;

    light_gate_speed_timer #(
        .SAMPLE_BITS (SAMPLE_W),
        .MAX_MINUTES (MAX_MIN)
    ) u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_start_sample (s_start_sample),
        .s_stop_sample  (s_stop_sample),
        .s_start_enable (s_start_enable),
        .s_clear        (s_clear),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_phase        (m_phase),
        .m_elapsed_ms   (m_elapsed_ms),
        .m_minutes      (m_minutes),
        .m_seconds      (m_seconds),
        .m_tenths       (m_tenths),
        .m_speed_centi  (m_speed_centi),
        .m_started      (m_started),
        .m_stopped      (m_stopped),
        .m_overflow     (m_overflow)
    );

    always #(CLK_PERIOD / 2.0) aclk = ~aclk;

    // ------------------------------------------------------------------------
    // bench state
    // ------------------------------------------------------------------------
    gate_result_t due_results [$];   // predicted results, oldest first
    int unsigned  ticks_sent   = 0;
    int unsigned  results_seen = 0;
    int unsigned  mismatches   = 0;
    int unsigned  cycle_count  = 0;
    bit           steady       = 1'b0;  // both sides stop idling while set

    // predictor copy of the registers, at their reset values
    logic [SAMPLE_W-1:0] cfg_start_thr = START_THR_RST;
    logic [SAMPLE_W-1:0] cfg_stop_thr  = STOP_THR_RST;
    logic [DIST_W-1:0]   cfg_dist      = DISTANCE_RST;

    // predictor copy of the timer state, all zero and idle after reset
    logic [PHASE_W-1:0] tm_phase = PH_IDLE;
    logic [MS_W-1:0]    tm_ms    = '0;
    logic               tm_armed = 1'b0;
    logic [SUB_W-1:0]   tm_sub   = '0;   // ms within the current tenth
    logic [TENTH_W-1:0] tm_tenth = '0;
    logic [SEC_W-1:0]   tm_sec   = '0;
    logic [MIN_W-1:0]   tm_min   = '0;
    logic [SPEED_W-1:0] tm_speed = '0;
    logic               tm_ovf   = 1'b0;

    // ------------------------------------------------------------------------
    // timer predictor
    // ------------------------------------------------------------------------
    function automatic void clear_timer();
        tm_ms    = '0;
        tm_armed = 1'b0;
        tm_sub   = '0;
        tm_tenth = '0;
        tm_sec   = '0;
        tm_min   = '0;
        tm_speed = '0;
        tm_ovf   = 1'b0;
    endfunction

    // Advances the timer by one tick and returns the result it shows.
    function automatic gate_result_t timer_response(tick_t t);
        gate_result_t r;
        int unsigned  quot;
        r = '0;
        if (t.clear) begin
            // clear beats any start or stop on the same tick
            tm_phase = PH_IDLE;
            clear_timer();
        end else if (tm_phase == PH_RUN) begin
            // count first, so a stop always sees at least one ms
            if (tm_ms >= MS_LIMIT) begin
                tm_ovf = 1'b1;
            end else begin
                tm_ms++;
                tm_sub++;
                if (tm_sub >= MS_PER_TENTH) begin
                    tm_sub = '0;
                    tm_tenth++;
                    if (tm_tenth >= TENTHS_PER_SEC) begin
                        tm_tenth = '0;
                        tm_sec++;
                        if (tm_sec >= SECS_PER_MIN) begin
                            tm_sec = '0;
                            tm_min++;
                        end
                    end
                end
                if (tm_ms >= MS_LIMIT)
                    tm_ovf = 1'b1;
            end
            if (t.stop_sample <= cfg_stop_thr) begin
                tm_armed = 1'b1;
            end else if (tm_armed) begin
                quot = (tm_ms == 0) ? 0 :
                       (32'(cfg_dist) * 32'(SPEED_SCALE)) / 32'(tm_ms);
                tm_speed = (quot > SPEED_MAX) ? SPEED_W'(SPEED_MAX) : SPEED_W'(quot);
                tm_phase = PH_DONE;
                r.stopped = 1'b1;
            end
        end else if (tm_phase == PH_IDLE) begin
            // stop beam is not looked at on the starting tick
            if (t.start_enable && t.start_sample > cfg_start_thr) begin
                clear_timer();
                tm_phase  = PH_RUN;
                r.started = 1'b1;
            end
        end
        // done: everything but clear is ignored, time and speed hold
        r.phase       = tm_phase;
        r.elapsed_ms  = tm_ms;
        r.minutes     = tm_min;
        r.seconds     = tm_sec;
        r.tenths      = tm_tenth;
        r.speed_centi = (tm_phase == PH_DONE) ? tm_speed : '0;
        r.overflow    = tm_ovf;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic logic [SAMPLE_W-1:0] beam_above(logic [SAMPLE_W-1:0] thr);
        // nothing lies above full scale; the caller then just gets full scale
        if (thr == SAMPLE_MAX)
            return thr;
        if ($urandom_range(0, 1))
            return thr + 1'b1;
        return SAMPLE_W'($urandom_range(int'(thr) + 1, SAMPLE_MAX));
    endfunction

    function automatic logic [SAMPLE_W-1:0] beam_below(logic [SAMPLE_W-1:0] thr);
        if ($urandom_range(0, 1))
            return thr;
        return SAMPLE_W'($urandom_range(0, int'(thr)));
    endfunction

    function automatic tick_t random_tick();
        tick_t t;
        t.start_sample = SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
        t.stop_sample  = SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
        t.start_enable = 1'($urandom_range(0, 1));
        t.clear        = ($urandom_range(0, 7) == 0);
        return t;
    endfunction

    // Offers one tick after a random gap (none while steady) and waits for the transaction.
    // The expectation is queued at the accepting edge.
    task automatic send_tick(tick_t t, logic typed = 1'b0, gate_result_t want = '0);
        int           gap;
        gate_result_t pred;
        gap = steady ? 0 : int'($urandom_range(0, MAX_GAP));
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid        <= 1'b1;
        s_start_sample <= t.start_sample;
        s_stop_sample  <= t.stop_sample;
        s_start_enable <= t.start_enable;
        s_clear        <= t.clear;
        do @(posedge aclk); while (s_ready !== 1'b1);
        pred = timer_response(t);
        due_results.push_back(typed ? want : pred);
        ticks_sent++;
    endtask

    // Register write; the predictor takes the same value, truncated alike.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [SAMPLE_W-1:0] data);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(negedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_START_THR: cfg_start_thr = data;
            REG_STOP_THR:  cfg_stop_thr  = data;
            REG_DISTANCE:  cfg_dist      = data[DIST_W-1:0];
            default: ;
        endcase
    endtask

    // Stops offering and waits until every queued result has arrived.
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (due_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic void match_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            if (mismatches < MAX_REPORTS)
                $display("%0t: %s expected %0d got %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // ------------------------------------------------------------------------
    // directed table, run with the registers at reset
    // ------------------------------------------------------------------------
    dir_row_t steps [18] = '{
        '{'{12'd4095, 12'd0,    1'b0, 1'b0}, 1'b1, R_IDLE},   // enable low, no start
        '{'{12'd170,  12'd0,    1'b1, 1'b0}, 1'b1, R_IDLE},   // at threshold, no start
        '{'{12'd171,  12'd0,    1'b1, 1'b0}, 1'b1, R_START},  // just above, starts
        '{'{12'd0,    12'd4095, 1'b0, 1'b0}, 1'b0, '0},       // stop high, not armed
        '{'{12'd0,    12'd200,  1'b0, 1'b0}, 1'b0, '0},       // at stop threshold: arms
        '{'{12'd0,    12'd201,  1'b0, 1'b0}, 1'b0, '0},       // stops at 3 ms
        '{'{12'd4095, 12'd0,    1'b1, 1'b0}, 1'b0, '0},       // done ignores start
        '{'{12'd4095, 12'd4095, 1'b1, 1'b1}, 1'b1, R_IDLE},   // clear from done
        '{'{12'd4095, 12'd4095, 1'b1, 1'b1}, 1'b1, R_IDLE},   // clear beats start
        '{'{12'd4095, 12'd0,    1'b1, 1'b0}, 1'b1, R_START},  // low stop on start tick
        '{'{12'd0,    12'd4095, 1'b1, 1'b0}, 1'b0, '0},       // ...did not arm
        '{'{12'd0,    12'd0,    1'b1, 1'b0}, 1'b0, '0},       // arm at zero
        '{'{12'd4095, 12'd4095, 1'b1, 1'b1}, 1'b1, R_IDLE},   // clear beats stop
        '{'{12'd0,    12'd4095, 1'b1, 1'b0}, 1'b1, R_IDLE},   // zero sample, no start
        '{'{12'd4095, 12'd4095, 1'b1, 1'b0}, 1'b1, R_START},  // full scale starts
        '{'{12'd4095, 12'd0,    1'b1, 1'b0}, 1'b0, '0},       // arm at 1 ms
        '{'{12'd4095, 12'd4095, 1'b0, 1'b0}, 1'b0, '0},       // fastest stop, 2 ms
        '{'{12'd0,    12'd0,    1'b0, 1'b1}, 1'b1, R_IDLE}    // clear
    };

    // ------------------------------------------------------------------------
    // run watchdog
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // result side: random back-pressure, one long hold-off, checking
    // ------------------------------------------------------------------------
    initial begin : result_sink
        gate_result_t got;
        gate_result_t want;
        int           stall;
        m_ready = 1'b1;
        forever begin
            stall = steady ? 0 : int'($urandom_range(0, MAX_GAP));
            // long hold-off: the block fills and must stall the tick side
            if (results_seen == HOLD_AT)
                stall = HOLD_CYCLES;
            if (stall > 0) begin
                @(negedge aclk);
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
                m_ready <= 1'b1;
            end
            do @(posedge aclk); while (m_valid !== 1'b1 || aresetn !== 1'b1);
            got = '{m_phase, m_elapsed_ms, m_minutes, m_seconds, m_tenths,
                    m_speed_centi, m_started, m_stopped, m_overflow};
            results_seen++;
            if (due_results.size() == 0) begin
                $display("%0t: result transaction with none expected, phase %0d ms %0d",
                         $time, got.phase, got.elapsed_ms);
                mismatches++;
            end else begin
                want = due_results.pop_front();
                match_field("phase",       32'(want.phase),       32'(got.phase));
                match_field("elapsed_ms",  32'(want.elapsed_ms),  32'(got.elapsed_ms));
                match_field("minutes",     32'(want.minutes),     32'(got.minutes));
                match_field("seconds",     32'(want.seconds),     32'(got.seconds));
                match_field("tenths",      32'(want.tenths),      32'(got.tenths));
                match_field("speed_centi", 32'(want.speed_centi), 32'(got.speed_centi));
                match_field("started",     32'(want.started),     32'(got.started));
                match_field("stopped",     32'(want.stopped),     32'(got.stopped));
                match_field("overflow",    32'(want.overflow),    32'(got.overflow));
            end
        end
    end

    // ------------------------------------------------------------------------
    // tick side: main sequence
    // ------------------------------------------------------------------------
    initial begin : tick_source
        tick_t       t;
        int unsigned stop_at;
        int unsigned run_len;

        // every input known from time zero; reset held for a fixed stretch
        aresetn        = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = REG_START_THR;
        cfg_wdata      = '0;
        s_valid        = 1'b0;
        s_start_sample = '0;
        s_stop_sample  = '0;
        s_start_enable = 1'b0;
        s_clear        = 1'b0;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed rows: thresholds, arming, clear priority, fastest stop
        for (int i = 0; i < $size(steps); i++)
            send_tick(steps[i].stim, steps[i].typed, steps[i].want);
        drain();

        // random part: one register setting per phase, extremes included
        for (int p = 0; p < $size(PHASE_TICKS); p++) begin
            case (p)
                0: begin
                    write_reg(REG_START_THR, SAMPLE_W'($urandom_range(0, SAMPLE_MAX)));
                    write_reg(REG_STOP_THR,  SAMPLE_W'($urandom_range(0, SAMPLE_MAX)));
                    write_reg(REG_DISTANCE,  SAMPLE_W'($urandom_range(0, 100)));
                end
                1: begin
                    // lowest everything: zero distance gives zero speed
                    write_reg(REG_START_THR, '0);
                    write_reg(REG_STOP_THR,  '0);
                    write_reg(REG_DISTANCE,  '0);
                end
                2: begin
                    // stop beam can never read above full scale: runs end by clear
                    write_reg(REG_START_THR, SAMPLE_W'(SAMPLE_MAX - 1));
                    write_reg(REG_STOP_THR,  SAMPLE_W'(SAMPLE_MAX));
                    write_reg(REG_DISTANCE,  SAMPLE_W'(100));
                end
                3: begin
                    // bits above the distance field are dropped: 127 dm, speed saturates on short runs
                    write_reg(REG_START_THR, SAMPLE_W'(2047));
                    write_reg(REG_STOP_THR,  SAMPLE_W'(2048));
                    write_reg(REG_DISTANCE,  SAMPLE_W'(SAMPLE_MAX));
                end
                default: begin
                    write_reg(REG_START_THR, SAMPLE_W'($urandom_range(0, SAMPLE_MAX)));
                    write_reg(REG_STOP_THR,  SAMPLE_W'($urandom_range(0, SAMPLE_MAX)));
                    write_reg(REG_DISTANCE,  SAMPLE_W'($urandom_range(0, 127)));
                end
            endcase

            stop_at = ticks_sent + PHASE_TICKS[p];
            while (ticks_sent < stop_at) begin
                // now and then a stretch with no idling on either side
                steady = ($urandom_range(0, 9) == 0);
                if ($urandom_range(0, 3) == 0) begin
                    // noise: fully random ticks, stray clears included
                    repeat ($urandom_range(1, 6)) send_tick(random_tick());
                end else begin
                    // a measurement: idle ticks that must not start
                    repeat ($urandom_range(0, 3)) begin
                        t = random_tick();
                        t.clear = 1'b0;
                        if (t.start_enable)
                            t.start_sample = beam_below(cfg_start_thr);
                        send_tick(t);
                    end
                    // start tick
                    t = random_tick();
                    t.clear        = 1'b0;
                    t.start_enable = 1'b1;
                    t.start_sample = beam_above(cfg_start_thr);
                    send_tick(t);
                    // stop beam still lit from the start: not armed yet
                    repeat ($urandom_range(0, 4)) begin
                        t = random_tick();
                        t.clear       = 1'b0;
                        t.stop_sample = beam_above(cfg_stop_thr);
                        send_tick(t);
                    end
                    // armed stretch; some runs long enough to carry tenths
                    run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 250)
                                                          : $urandom_range(1, 15);
                    repeat (run_len) begin
                        t = random_tick();
                        t.clear       = 1'b0;
                        t.stop_sample = beam_below(cfg_stop_thr);
                        send_tick(t);
                    end
                    // most runs stop and sit in done; a few are cleared mid-run
                    if ($urandom_range(0, 9) != 0) begin
                        t = random_tick();
                        t.clear       = 1'b0;
                        t.stop_sample = beam_above(cfg_stop_thr);
                        send_tick(t);
                        repeat ($urandom_range(0, 3)) begin
                            t = random_tick();
                            t.clear = 1'b0;
                            send_tick(t);
                        end
                    end
                    t = random_tick();
                    t.clear = 1'b1;
                    send_tick(t);
                end
            end
            steady = 1'b0;
            drain();
        end

        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== light_gate_speed_timer.f =====
rtl/lgst_pkg.sv
rtl/lgst_ctrl.sv
rtl/lgst_dp.sv
rtl/light_gate_speed_timer.sv
sim/testbench.sv
